// ----- hdl/dsrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dsrc_pkg;

  // Debounce limit register
  localparam int unsigned LIMIT_W = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);
  localparam logic [LIMIT_W-1:0] LIMIT_MIN = LIMIT_W'(1);
  localparam logic [LIMIT_W-1:0] COUNT_RESET = LIMIT_W'(5 / 2);

  // Relay command and pulse timer widths
  localparam int unsigned CMD_W = 21;
  localparam int unsigned PULSE_BITS = 20;
  localparam int unsigned SAT_W = (CMD_W > PULSE_BITS) ? CMD_W : PULSE_BITS;
  localparam logic [PULSE_BITS-1:0] PULSE_MAX = '1;

  // Item kinds
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_COMMAND = 2'd1,
    OP_MS_TICK = 2'd2
  } op_e;

  // Relay target addressed by a command
  localparam logic TARGET_RELAY = 1'b0;

endpackage

`default_nettype wire

// ----- hdl/debounced_switch_relay_controller_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Debounced wall switch and relay driver.
// Input channel (in_valid_i / in_stall_o) carries one item per transfer:
// a switch sample tick, a relay command or a millisecond tick, chosen by
// opcode_i. Every item gives exactly one result on the output channel
// (out_valid_o / out_stall_i): relay level, debounced switch level, pulse
// flag and a changed flag.
// The result is registered and offered from the cycle after the item is
// accepted. Throughput is one item per cycle while no result waits under
// stall, set by the single result register; the state update for an item
// completes at its accepting edge, so the next item follows without a gap.
// When a result waits and the receiver stalls, the result register holds and
// in_stall_o rises in the same cycle, so no item is taken until the result is
// transferred. Write the debounce limit through cfg_we_i / cfg_wdata_i only
// while the block is idle; the block does not enforce this. A written zero
// acts as one. Reset sets the limit to 5, the integrator to 2, the switch and
// relay off, stops any pulse and empties the result register.

module debounced_switch_relay_controller_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [dsrc_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [1:0]                    opcode_i,
  input  wire                          switch_level_i,
  input  wire                          target_index_i,
  input  wire signed [dsrc_pkg::CMD_W-1:0] command_value_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         relay_on_o,
  output logic                         switch_state_o,
  output logic                         pulse_active_o,
  output logic                         changed_o
);

  logic [dsrc_pkg::LIMIT_W-1:0]    limit_q;
  logic [dsrc_pkg::LIMIT_W-1:0]    count_q, count_d;
  logic                            stable_q, stable_d;
  logic                            relay_q, relay_d;
  logic [dsrc_pkg::PULSE_BITS-1:0] remain_q, remain_d;
  logic                            running_q, running_d;

  logic                            out_valid_q, out_valid_d;
  logic                            relay_out_q, switch_out_q, pulse_out_q, changed_q;

  logic                            in_xfer;
  logic                            hit;
  logic                            cmd_neg;
  logic [dsrc_pkg::CMD_W-1:0]      cmd_u;
  logic [dsrc_pkg::CMD_W-1:0]      neg_mag;
  logic [dsrc_pkg::SAT_W-1:0]      mag_ext;
  logic [dsrc_pkg::PULSE_BITS-1:0] pulse_len;
  logic [dsrc_pkg::PULSE_BITS-1:0] remain_dec;

  // Handshake: take an item unless a result is waiting under stall
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_valid_d = in_xfer | (out_valid_q & out_stall_i);

  // Command magnitude and pulse length, saturated to the timer width
  assign cmd_u     = $unsigned(command_value_i);
  assign cmd_neg   = cmd_u[dsrc_pkg::CMD_W-1];
  assign neg_mag   = (~cmd_u) + dsrc_pkg::CMD_W'(1);
  assign mag_ext   = dsrc_pkg::SAT_W'(neg_mag);
  assign pulse_len = (mag_ext > dsrc_pkg::SAT_W'(dsrc_pkg::PULSE_MAX)) ?
                     dsrc_pkg::PULSE_MAX : dsrc_pkg::PULSE_BITS'(mag_ext);
  assign remain_dec = (remain_q == '0) ? '0 : remain_q - dsrc_pkg::PULSE_BITS'(1);

  // Next state for one item
  always_comb begin
    count_d   = count_q;
    stable_d  = stable_q;
    relay_d   = relay_q;
    remain_d  = remain_q;
    running_d = running_q;
    hit       = 1'b0;
    unique case (dsrc_pkg::op_e'(opcode_i))
      dsrc_pkg::OP_SAMPLE: begin
        if (switch_level_i) begin
          if (count_q < limit_q) begin
            count_d = count_q + dsrc_pkg::LIMIT_W'(1);
            hit     = (count_d == limit_q);
          end
        end else if (count_q != '0) begin
          count_d = count_q - dsrc_pkg::LIMIT_W'(1);
          hit     = (count_d == '0);
        end
        // A new debounced level toggles the relay unless a pulse locks it
        if (hit && ((count_d == limit_q) != stable_q)) begin
          stable_d = (count_d == limit_q);
          if (!running_q) begin
            relay_d = ~relay_q;
          end
        end
      end
      dsrc_pkg::OP_COMMAND: begin
        if ((target_index_i == dsrc_pkg::TARGET_RELAY) && !running_q) begin
          if (cmd_neg) begin
            remain_d  = pulse_len;
            running_d = 1'b1;
            relay_d   = 1'b1;
          end else if (cmd_u != dsrc_pkg::CMD_W'(relay_q)) begin
            relay_d = (cmd_u > dsrc_pkg::CMD_W'(1)) ? ~relay_q : cmd_u[0];
          end
        end
      end
      dsrc_pkg::OP_MS_TICK: begin
        // Count the pulse down and drop the relay when it runs out
        if (running_q) begin
          remain_d = remain_dec;
          if (remain_dec == '0) begin
            running_d = 1'b0;
            relay_d   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= dsrc_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= (cfg_wdata_i == '0) ? dsrc_pkg::LIMIT_MIN : cfg_wdata_i;
    end
  end

  // Block state, advanced on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= dsrc_pkg::COUNT_RESET;
      stable_q  <= 1'b0;
      relay_q   <= 1'b0;
      remain_q  <= '0;
      running_q <= 1'b0;
    end else if (in_xfer) begin
      count_q   <= count_d;
      stable_q  <= stable_d;
      relay_q   <= relay_d;
      remain_q  <= remain_d;
      running_q <= running_d;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      relay_out_q  <= relay_d;
      switch_out_q <= stable_d;
      pulse_out_q  <= running_d;
      changed_q    <= (relay_d != relay_q) || (stable_d != stable_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign relay_on_o     = relay_out_q;
  assign switch_state_o = switch_out_q;
  assign pulse_active_o = pulse_out_q;
  assign changed_o      = changed_q;

endmodule

`default_nettype wire

// ----- hdl/dsrc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsrc_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire out_valid_o,
  input wire out_stall_i,
  input wire relay_on_o,
  input wire switch_state_o,
  input wire pulse_active_o,
  input wire changed_o
);

  logic out_xfer;
  logic last_relay_q;
  logic last_switch_q;

  assign out_xfer = out_valid_o & ~out_stall_i;

  // Track the levels of the last transferred result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_relay_q  <= 1'b0;
      last_switch_q <= 1'b0;
    end else if (out_xfer) begin
      last_relay_q  <= relay_on_o;
      last_switch_q <= switch_state_o;
    end
  end

  // A running pulse always drives the relay on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pulse_active_o |-> relay_on_o)
    else $error("pulse active with relay off");

  // The changed flag matches the levels against the previous result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> changed_o ==
      ((relay_on_o != last_relay_q) || (switch_state_o != last_switch_q)))
    else $error("changed flag disagrees with result sequence");

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  // A stalled result holds its levels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(relay_on_o) && $stable(switch_state_o))
    else $error("result changed under stall");

endmodule

bind debounced_switch_relay_controller_core dsrc_checker u_dsrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .relay_on_o     (relay_on_o),
  .switch_state_o (switch_state_o),
  .pulse_active_o (pulse_active_o),
  .changed_o      (changed_o)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  // Widths and reset values taken from the package
  localparam int unsigned                      CMD_W       = dsrc_pkg::CMD_W;
  localparam int unsigned                      LIMIT_W     = dsrc_pkg::LIMIT_W;
  localparam int unsigned                      PULSE_BITS  = dsrc_pkg::PULSE_BITS;
  localparam logic [dsrc_pkg::PULSE_BITS-1:0]  PULSE_MAX   = dsrc_pkg::PULSE_MAX;
  localparam logic [dsrc_pkg::LIMIT_W-1:0]     LIMIT_MIN   = dsrc_pkg::LIMIT_MIN;
  localparam logic [dsrc_pkg::LIMIT_W-1:0]     LIMIT_RESET = dsrc_pkg::LIMIT_RESET;
  localparam logic [dsrc_pkg::LIMIT_W-1:0]     COUNT_RESET = dsrc_pkg::COUNT_RESET;

  // Codes the package does not name
  localparam logic [1:0]       OP_UNUSED     = 2'd3;
  localparam logic             TARGET_SWITCH = 1'b1;
  localparam logic [CMD_W-1:0] CMD_OFF       = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_ON        = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_TOGGLE    = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_MAX_POS   = {1'b0, {(CMD_W-1){1'b1}}};
  localparam logic [CMD_W-1:0] CMD_MIN_NEG   = {1'b1, {(CMD_W-1){1'b0}}};

  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic relay;
    logic sw;
    logic pulse;
    logic changed;
  } relay_status_t;

  // DUT ports, inputs all known from time zero
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [LIMIT_W-1:0]      cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              opcode_i = dsrc_pkg::OP_SAMPLE;
  logic                    switch_level_i = 1'b0;
  logic                    target_index_i = dsrc_pkg::TARGET_RELAY;
  logic signed [CMD_W-1:0] command_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    relay_on_o;
  logic                    switch_state_o;
  logic                    pulse_active_o;
  logic                    changed_o;

  // Predicted block state
  logic [LIMIT_W-1:0]    dbc_limit;
  logic [LIMIT_W-1:0]    dbc_count;
  logic                  sw_stable;
  logic                  relay_lvl;
  logic [PULSE_BITS-1:0] pulse_left;
  logic                  pulse_on;

  relay_status_t relay_status_q[$];

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic holding = 1'b0;
  event hold_go;

  int mismatches = 0;
  int item_count = 0;
  int ignored_count = 0;
  int result_count = 0;
  int change_count = 0;
  int cycle_count = 0;

  debounced_switch_relay_controller_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .switch_level_i  (switch_level_i),
    .target_index_i  (target_index_i),
    .command_value_i (command_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .relay_on_o      (relay_on_o),
    .switch_state_o  (switch_state_o),
    .pulse_active_o  (pulse_active_o),
    .changed_o       (changed_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Hold off the result side for a fixed stretch on request
  initial begin
    forever begin
      @(hold_go);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      holding <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Relay and debounce prediction
  // ---------------------------------------------------------------------------

  // Apply a relay command; neg selects a timed pulse of length mag
  function automatic void drive_relay(logic neg, logic [CMD_W:0] mag);
    if (pulse_on) return;
    if (!neg && mag == (CMD_W+1)'(relay_lvl)) return;
    if (neg) begin
      pulse_left = (mag > (CMD_W+1)'(PULSE_MAX)) ? PULSE_MAX : mag[PULSE_BITS-1:0];
      pulse_on = 1'b1;
      relay_lvl = 1'b1;
    end else if (mag > 1) begin
      relay_lvl = ~relay_lvl;
    end else begin
      relay_lvl = mag[0];
    end
  endfunction

  function automatic relay_status_t predict_relay_status(logic [1:0] op, logic lvl,
                                                         logic tgt, logic [CMD_W-1:0] cmd);
    relay_status_t st;
    logic          old_relay;
    logic          old_sw;
    logic          hit;
    logic [CMD_W:0] wide;

    old_relay = relay_lvl;
    old_sw = sw_stable;
    hit = 1'b0;
    wide = {cmd[CMD_W-1], cmd};
    if (op == dsrc_pkg::OP_SAMPLE) begin
      // Integrate toward the raw level, saturating at both ends
      if (lvl) begin
        if (dbc_count < dbc_limit) begin
          dbc_count++;
          hit = (dbc_count == dbc_limit);
        end
      end else if (dbc_count > 0) begin
        dbc_count--;
        hit = (dbc_count == 0);
      end
      if (hit && ((dbc_count == dbc_limit) != sw_stable)) begin
        sw_stable = (dbc_count == dbc_limit);
        drive_relay(1'b0, (CMD_W+1)'(CMD_TOGGLE));
      end
    end else if (op == dsrc_pkg::OP_COMMAND) begin
      if (tgt == dsrc_pkg::TARGET_RELAY)
        drive_relay(cmd[CMD_W-1], cmd[CMD_W-1] ? (~wide + 1'b1) : wide);
    end else if (op == dsrc_pkg::OP_MS_TICK) begin
      // Count the pulse down and drop the relay when it runs out
      if (pulse_on) begin
        if (pulse_left > 0) pulse_left--;
        if (pulse_left == 0) begin
          pulse_on = 1'b0;
          drive_relay(1'b0, (CMD_W+1)'(CMD_OFF));
        end
      end
    end
    st.relay = relay_lvl;
    st.sw = sw_stable;
    st.pulse = pulse_on;
    st.changed = (relay_lvl != old_relay) || (sw_stable != old_sw);
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall at random and check every transfer
  // ---------------------------------------------------------------------------

  function automatic void compare_bit(string name, logic exp_v, logic act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0b, got %0b", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    relay_status_t exp_st;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (relay_status_q.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatches++;
      end else begin
        exp_st = relay_status_q.pop_front();
        compare_bit("relay_on", exp_st.relay, relay_on_o);
        compare_bit("switch_state", exp_st.sw, switch_state_o);
        compare_bit("pulse_active", exp_st.pulse, pulse_active_o);
        compare_bit("changed", exp_st.changed, changed_o);
        result_count++;
        if (exp_st.changed) change_count++;
      end
    end
    out_stall_i <= holding || ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Item side
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic [1:0] op, input logic lvl, input logic tgt,
                           input logic [CMD_W-1:0] cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    switch_level_i <= lvl;
    target_index_i <= tgt;
    command_value_i <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    relay_status_q.push_back(predict_relay_status(op, lvl, tgt, cmd));
    item_count++;
    if (op == OP_UNUSED || (op == dsrc_pkg::OP_COMMAND && tgt != dsrc_pkg::TARGET_RELAY))
      ignored_count++;
  endtask

  task automatic sample(input logic lvl);
    send_item(dsrc_pkg::OP_SAMPLE, lvl, 1'($urandom), CMD_W'($urandom));
  endtask

  task automatic relay_cmd(input logic [CMD_W-1:0] val);
    send_item(dsrc_pkg::OP_COMMAND, 1'($urandom), dsrc_pkg::TARGET_RELAY, val);
  endtask

  task automatic ms_tick();
    send_item(dsrc_pkg::OP_MS_TICK, 1'($urandom), 1'($urandom), CMD_W'($urandom));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (relay_status_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dbc_limit = (val == 0) ? LIMIT_MIN : val;
    @(posedge clk_i);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // One random burst: mostly debounce runs and relay traffic, some noise
  task automatic random_burst();
    int             pick;
    logic           lvl;
    logic [CMD_W-1:0] val;

    pick = $urandom_range(99);
    if (pick < 45) begin
      lvl = 1'($urandom);
      repeat ($urandom_range(1, dbc_limit + 2))
        sample(($urandom_range(9) == 0) ? ~lvl : lvl);
    end else if (pick < 70) begin
      case ($urandom_range(3))
        0: val = CMD_OFF;
        1: val = CMD_ON;
        2: val = CMD_W'($urandom_range(CMD_MAX_POS, 2));
        default: val = CMD_W'(-$urandom_range(12, 1));
      endcase
      relay_cmd(val);
    end else if (pick < 88) begin
      repeat ($urandom_range(8, 1)) ms_tick();
    end else begin
      case ($urandom_range(2))
        0: send_item(OP_UNUSED, 1'($urandom), 1'($urandom), CMD_W'($urandom));
        1: send_item(dsrc_pkg::OP_COMMAND, 1'($urandom), TARGET_SWITCH, CMD_W'($urandom));
        default: sample(1'($urandom));
      endcase
    end
  endtask

  task automatic run_random(input int n);
    int goal;
    goal = item_count - ignored_count + n;
    while (item_count - ignored_count < goal) random_burst();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset limit and count: switch on and off, the off edge locked by a pulse
  task automatic test_debounce();
    set_idle(16, 16);
    repeat (3) sample(1'b1);
    sample(1'b0);
    sample(1'b1);
    relay_cmd(CMD_W'(-2));
    repeat (5) sample(1'b0);
    repeat (2) ms_tick();
    wait_idle();
  endtask

  // Every command form, redundant and locked commands, unused codes
  task automatic test_commands();
    set_idle(0, 0);
    ms_tick();
    send_item(OP_UNUSED, 1'b1, TARGET_SWITCH, CMD_MAX_POS);
    send_item(dsrc_pkg::OP_COMMAND, 1'b0, TARGET_SWITCH, CMD_ON);
    relay_cmd(CMD_OFF);
    relay_cmd(CMD_ON);
    relay_cmd(CMD_ON);
    relay_cmd(CMD_TOGGLE);
    relay_cmd(CMD_MAX_POS);
    relay_cmd(CMD_W'(-3));
    relay_cmd(CMD_OFF);
    relay_cmd(CMD_TOGGLE);
    repeat (3) ms_tick();
    relay_cmd(CMD_W'(-1));
    relay_cmd(CMD_W'(-5));
    ms_tick();
    ms_tick();
    wait_idle();
  endtask

  // Widest limit, limit lowered below the count, and a written zero
  task automatic test_limit_extremes();
    set_idle(16, 16);
    write_limit('1);
    repeat (260) sample(1'b1);
    write_limit(LIMIT_W'(4));
    repeat (3) sample(1'b1);
    repeat (256) sample(1'b0);
    write_limit('0);
    sample(1'b1);
    sample(1'b1);
    sample(1'b0);
    write_limit(LIMIT_RESET);
  endtask

  // Most negative command saturates to the full pulse length; the pulse keeps
  // running and locks out commands for the rest of the run
  task automatic test_long_pulse();
    set_idle(0, 0);
    while (pulse_on) ms_tick();
    relay_cmd(CMD_MIN_NEG);
    repeat (3) ms_tick();
    relay_cmd(CMD_OFF);
    relay_cmd(CMD_W'(-1));
    ms_tick();
    wait_idle();
  endtask

  // Hold the result side while items keep coming, then drain fully
  task automatic test_backpressure();
    set_idle(0, 0);
    -> hold_go;
    run_random(40);
    wait_idle();
  endtask

  task automatic test_random();
    set_idle(0, 0);
    write_limit(LIMIT_MIN);
    run_random(160);
    set_idle(60, 0);
    write_limit(LIMIT_W'($urandom_range(6, 2)));
    run_random(160);
    set_idle(0, 60);
    write_limit(LIMIT_W'($urandom_range(12, 2)));
    run_random(160);
    set_idle(16, 16);
    write_limit(LIMIT_W'($urandom_range(40, 20)));
    run_random(170);
    wait_idle();
  endtask

  initial begin
    dbc_limit = LIMIT_RESET;
    dbc_count = COUNT_RESET;
    sw_stable = 1'b0;
    relay_lvl = 1'b0;
    pulse_left = '0;
    pulse_on = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_debounce();
    test_commands();
    test_limit_extremes();
    test_backpressure();
    test_random();
    test_long_pulse();

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("sent %0d items (%0d ignored by design), checked %0d results, %0d with a change",
             item_count, ignored_count, result_count, change_count);
    $display("covered commands, pulses and a saturated pulse start, limits 1..255, stalls");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/dsrc_pkg.sv
hdl/debounced_switch_relay_controller_core.sv
hdl/dsrc_checker.sv
tb/sv/testbench.sv
